FILE: rtl/plc_pkg.sv
// Package for the piecewise-linear calibrator: request and position codes,
// divider sideband type and fixed widths. No dependencies.
`timescale 1ns / 1ps
package plc_pkg;

  localparam int VAL_W = 16;  // breakpoint and reading width
  localparam int DIV_W = 32;  // dividend (product) width
  localparam int DEN_W = 16;  // divisor width, b - a of a rising pair

  typedef enum logic [1:0] {
    REQ_RAW  = 2'd0,
    REQ_NORM = 2'd1,
    REQ_CONV = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    POS_WITHIN = 2'd0,
    POS_BELOW  = 2'd1,
    POS_ABOVE  = 2'd2
  } pos_t;

  // Travels beside the quotient through the divider.
  typedef struct packed {
    logic signed [VAL_W-1:0] c;    // offset added to the quotient
    logic [3:0]              seg;
    pos_t                    pos;
    logic                    neg;  // quotient sign
  } side_t;

endpackage

FILE: rtl/plc_in_if.sv
// Input channel interface of the calibrator.
// Depends on nothing.
`timescale 1ns / 1ps
interface plc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [2:0]         sensor;
  logic [3:0]         point;
  logic signed [15:0] value;
  modport source (output valid, req_type, sensor, point, value, input ready);
  modport sink   (input valid, req_type, sensor, point, value, output ready);
endinterface

FILE: rtl/plc_out_if.sv
// Result channel interface of the calibrator.
// Depends on nothing.
`timescale 1ns / 1ps
interface plc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normalized;
  logic [3:0]         segment;
  logic [1:0]         position;
  modport source (output valid, normalized, segment, position, input ready);
  modport sink   (input valid, normalized, segment, position, output ready);
endinterface

FILE: rtl/plc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module plc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/plc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on plc_pkg.
`timescale 1ns / 1ps
module plc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [plc_pkg::DIV_W-1:0]    in_num,
  input  logic [plc_pkg::DEN_W-1:0]    in_den,
  input  plc_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [plc_pkg::DIV_W-1:0]    out_quo,
  output plc_pkg::side_t               out_side
);
  import plc_pkg::*;

  logic             v_r [DIV_W+1];
  logic [DIV_W-1:0] q_r [DIV_W+1];
  logic [DEN_W-1:0] r_r [DIV_W+1];
  logic [DEN_W-1:0] d_r [DIV_W+1];
  side_t            s_r [DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      q_r[0] <= in_num;
      r_r[0] <= '0;
      d_r[0] <= in_den;
      s_r[0] <= in_side;
    end
  end

  for (genvar j = 0; j < DIV_W; j++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;

    always_comb begin
      trial   = {r_r[j], q_r[j][DIV_W-1]};
      diff    = trial - {1'b0, d_r[j]};
      ge      = (trial >= {1'b0, d_r[j]});
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
      if (en) begin
        q_r[j+1] <= {q_r[j][DIV_W-2:0], ge};
        r_r[j+1] <= rem_nxt;
        d_r[j+1] <= d_r[j];
        s_r[j+1] <= s_r[j];
      end
    end
  end

  assign out_valid = v_r[DIV_W];
  assign out_quo   = q_r[DIV_W];
  assign out_side  = s_r[DIV_W];
endmodule

FILE: rtl/piecewise_linear_calibrator_top.sv
// Top level of the piecewise-linear calibrator: tables, search, multiply,
// divider and output register. Depends on plc_pkg, plc_in_if, plc_out_if,
// plc_ram and plc_div.
//
//   channel   | dir | handshake        | word
//   ----------+-----+------------------+------------------------------------
//   in_word   | in  | valid/ready      | req_type, sensor, point, value
//   out_word  | out | valid/ready      | normalized, segment, position
//   cfg_      | in  | cfg_we           | cfg_wdata = segments in use
//
// One word enters per cycle while the output is not stalled. A convert passes
// 38 register stages: RAM read, search, difference, multiply, sign into the
// divider input, 32 stages of the pipelined divider (one quotient bit each) and
// the output register. Table writes complete at acceptance and return nothing.
// Reset is synchronous and clears valid bits and the segment count (2); table
// contents are undefined until written. A stalled output freezes the whole pipe.
`timescale 1ns / 1ps
module piecewise_linear_calibrator_top #(
  parameter int SENSORS = 8,
  parameter int POINTS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  plc_in_if.sink     in_word,
  plc_out_if.source  out_word,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);
  import plc_pkg::*;

  localparam int PW = $clog2(POINTS);
  localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  // ---------------- config and pipe control ----------------
  logic [3:0] seg_cnt_r;
  logic [PW-1:0] s_eff;
  logic adv, acc, sensor_ok, point_ok, raw_we, norm_we, conv;
  req_t req;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= 4'd2;
    end else if (cfg_we) begin
      seg_cnt_r <= cfg_wdata;
    end
  end

  // segment count limited to the table size
  assign s_eff = (32'(seg_cnt_r) > POINTS - 1) ? PW'(POINTS - 1) : PW'(seg_cnt_r);

  assign adv           = !out_valid_r || out_word.ready;
  assign in_word.ready = adv;
  assign acc           = in_word.valid && adv;
  assign req           = req_t'(in_word.req_type);
  assign sensor_ok     = 32'(in_word.sensor) < SENSORS;
  assign point_ok      = 32'(in_word.point) < POINTS;
  assign raw_we        = acc && (req == REQ_RAW) && sensor_ok && point_ok;
  assign norm_we       = acc && (req == REQ_NORM) && point_ok;
  assign conv          = acc && (req == REQ_CONV) && sensor_ok;

  // ---------------- stage 0: raw table, one bank per point ----------------
  logic [VAL_W-1:0] bp [POINTS];

  for (genvar p = 0; p < POINTS; p++) begin : g_bank
    plc_ram #(.WIDTH(VAL_W), .DEPTH(SENSORS)) u_raw (
      .clk   (clk),
      .we    (raw_we && (32'(in_word.point) == p)),
      .waddr (SW'(in_word.sensor)),
      .wdata (in_word.value),
      .re    (adv),
      .raddr (SW'(in_word.sensor)),
      .rdata (bp[p])
    );
  end

  // ---------------- stage 1: breakpoint search ----------------
  logic                    v1_r;
  logic signed [VAL_W-1:0] x1_r;
  logic                    hit_any;
  logic [PW-1:0]           found, k1, na, nb;
  pos_t                    pos1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= conv;
    end
    if (adv) begin
      x1_r <= in_word.value;
    end
  end

  // first point at or above the reading
  always_comb begin
    hit_any = 1'b0;
    found   = '0;
    for (int i = POINTS - 1; i >= 0; i--) begin
      if ((PW'(i) <= s_eff) && (x1_r <= $signed(bp[i]))) begin
        hit_any = 1'b1;
        found   = PW'(i);
      end
    end
  end

  always_comb begin
    k1 = found - PW'(1);
    if (!hit_any) begin
      pos1 = POS_ABOVE;
      na   = s_eff;
    end else if (found == '0) begin
      pos1 = POS_BELOW;
      na   = '0;
    end else begin
      pos1 = POS_WITHIN;
      na   = k1;
    end
    nb = found;
  end

  // normalized table, two copies for the two segment ends
  logic [VAL_W-1:0] n_c, n_d;

  plc_ram #(.WIDTH(VAL_W), .DEPTH(POINTS)) u_norm_c (
    .clk   (clk),
    .we    (norm_we),
    .waddr (PW'(in_word.point)),
    .wdata (in_word.value),
    .re    (adv),
    .raddr (na),
    .rdata (n_c)
  );

  plc_ram #(.WIDTH(VAL_W), .DEPTH(POINTS)) u_norm_d (
    .clk   (clk),
    .we    (norm_we),
    .waddr (PW'(in_word.point)),
    .wdata (in_word.value),
    .re    (adv),
    .raddr (nb),
    .rdata (n_d)
  );

  // ---------------- stage 2: differences ----------------
  logic                    v2_r;
  logic signed [VAL_W-1:0] x2_r, a2_r, b2_r;
  logic [3:0]              seg2_r;
  pos_t                    pos2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      x2_r   <= x1_r;
      a2_r   <= $signed(bp[k1]);
      b2_r   <= $signed(bp[found]);
      seg2_r <= (pos1 == POS_WITHIN) ? 4'(k1) : 4'd0;
      pos2_r <= pos1;
    end
  end

  logic signed [VAL_W:0] dx2, dn2;
  logic [VAL_W:0]        den2;
  logic                  within2;

  assign within2 = (pos2_r == POS_WITHIN);
  assign dx2  = within2 ? ({x2_r[VAL_W-1], x2_r} - {a2_r[VAL_W-1], a2_r}) : '0;
  assign dn2  = $signed({n_d[VAL_W-1], n_d}) - $signed({n_c[VAL_W-1], n_c});
  assign den2 = {b2_r[VAL_W-1], b2_r} - {a2_r[VAL_W-1], a2_r};

  // ---------------- stage 3: multiply ----------------
  logic                    v3_r;
  logic signed [VAL_W:0]   dx3_r, dn3_r;
  logic [DEN_W-1:0]        den3_r;
  side_t                   side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      dx3_r       <= dx2;
      dn3_r       <= dn2;
      den3_r      <= within2 ? den2[DEN_W-1:0] : DEN_W'(1);
      side3_r.c   <= $signed(n_c);
      side3_r.seg <= seg2_r;
      side3_r.pos <= pos2_r;
      side3_r.neg <= 1'b0;
    end
  end

  logic signed [2*VAL_W+1:0] prod3;
  assign prod3 = dx3_r * dn3_r;

  // ---------------- stage 4: product, 32-bit wrap ----------------
  logic             v4_r;
  logic [DIV_W-1:0] p4_r;
  logic [DEN_W-1:0] den4_r;
  side_t            side4_r, side4;
  logic [DIV_W-1:0] mag4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      p4_r    <= prod3[DIV_W-1:0];
      den4_r  <= den3_r;
      side4_r <= side3_r;
    end
  end

  // magnitude for the unsigned divider; sign restored at the end
  always_comb begin
    side4     = side4_r;
    side4.neg = p4_r[DIV_W-1];
    mag4      = p4_r[DIV_W-1] ? (~p4_r + DIV_W'(1)) : p4_r;
  end

  // ---------------- divider ----------------
  logic             dv_valid;
  logic [DIV_W-1:0] dv_quo;
  side_t            dv_side;

  plc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v4_r),
    .in_num    (mag4),
    .in_den    (den4_r),
    .in_side   (side4),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // ---------------- output register ----------------
  logic [VAL_W-1:0] q_lo, norm_nxt;
  logic [VAL_W-1:0] norm_r;
  logic [3:0]       seg_r;
  pos_t             pos_r;

  assign q_lo     = dv_side.neg ? (~dv_quo[VAL_W-1:0] + VAL_W'(1)) : dv_quo[VAL_W-1:0];
  assign norm_nxt = q_lo + dv_side.c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
    if (adv) begin
      norm_r <= norm_nxt;
      seg_r  <= dv_side.seg;
      pos_r  <= dv_side.pos;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.normalized = $signed(norm_r);
  assign out_word.segment    = seg_r;
  assign out_word.position   = pos_r;

  // ---------------- assertions ----------------
  // a clamped result always reports segment zero
  a_clamp_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (pos_r != POS_WITHIN)) |-> (seg_r == 4'd0))
    else $error("clamped result with nonzero segment");

  // only a convert word occupies the search stage
  a_write_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_word.req_type != REQ_CONV)) |=> !v1_r)
    else $error("non-convert word entered the pipe");

  // a stalled output holds the whole pipe
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |=> ($stable(v4_r) && $stable(p4_r)))
    else $error("pipe moved during output stall");

endmodule
